@@ hw/rtl/pvbu_pkg.sv @@
// Shared constants and control types of the phase vocoder bin update unit.
`default_nettype none
package pvbu_pkg;
   // Configuration and index widths.
   localparam int LEN_W = 17;
   localparam int BIN_W = 16;
   localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;

   // Fixed-point layout of the unit phasor and the normalized reference.
   localparam int Q_FRAC = 30;
   localparam int NORM_W = Q_FRAC;
   localparam int NORM_TOP = Q_FRAC - 1;
   localparam int ROOT_W = Q_FRAC + 1;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int QUO_W = Q_FRAC + 1;
   localparam int NUM_W = 2 * Q_FRAC + 1;

   // Flags that follow the reference phasor: signs of its parts and zero.
   localparam int FLG_W = 3;

   // Pipeline control handed to every section.
   typedef struct packed {
      logic adv;
      logic valid;
   } pipe_ctl_type;
endpackage
`default_nettype wire

@@ hw/rtl/phase_vocoder_bin_update_unit.sv @@
// Top level of the phase vocoder bin update unit.
`default_nettype none
// Phase-locked bin update: each transaction carries one FFT bin of the start
// analysis, end analysis and previous synthesis spectra and returns the end
// bin rotated by the unit phasor of Yold * conj(Xs), saturated, with flags for
// a zero reference and for clipping. Bin 0 and the Nyquist bin of an even
// fft_length are treated as real. The unit takes one transaction every cycle
// while no result is held and passes it through 7 front stages (capture,
// products, phasor, leading-one search, normalization, squares, radicand),
// 31 square-root, 31 divider and 3 output stages. The whole pipeline holds
// while a result waits under rsp_stall, so req_stall follows rsp_stall when
// the output register is full. Write csr_wr_data only while the unit is idle.
module phase_vocoder_bin_update_unit
   import pvbu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [LEN_W-1:0]                  csr_wr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [BIN_W-1:0]                  req_bin_index,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_start_real,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_start_imag,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_end_real,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_end_imag,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_prev_real,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_prev_imag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [BIN_W-1:0]                       rsp_result_bin,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_real,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_imag,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_clipped
);
   localparam int SIDE_W = BIN_W + 3 + 3 * SAMPLE_WIDTH;
   localparam int STAG_W = 2 * NORM_W + SIDE_W + FLG_W;
   localparam int DTAG_W = SIDE_W + FLG_W;

   // Transform length register.
   logic [LEN_W-1:0] len_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // The pipeline moves unless a finished result is held.
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic f_valid, q_valid, d_valid;
   logic [RAD_W-1:0] f_rad;
   logic [NORM_W-1:0] f_mr, f_mi, q_mr, q_mi;
   logic [SIDE_W-1:0] f_side, q_side, d_side;
   logic [FLG_W-1:0] f_flg, q_flg, d_flg;
   logic [ROOT_W-1:0] q_root;
   logic [STAG_W-1:0] q_tag;
   logic [DTAG_W-1:0] d_tag;
   logic [QUO_W-1:0] d_cm, d_sm;
   logic [NUM_W-1:0] num_a, num_b;

   pvbu_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    ('{adv: adv, valid: req_valid}),
      .fft_len   (len_ff),
      .bin_in    (req_bin_index),
      .sr_in     (req_start_real),
      .si_in     (req_start_imag),
      .er_in     (req_end_real),
      .ei_in     (req_end_imag),
      .yr_in     (req_prev_real),
      .yi_in     (req_prev_imag),
      .valid_out (f_valid),
      .rad_out   (f_rad),
      .mr_out    (f_mr),
      .mi_out    (f_mi),
      .side_out  (f_side),
      .flg_out   (f_flg)
   );

   pvbu_sqrt #(.TAG_W(STAG_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    ('{adv: adv, valid: f_valid}),
      .rad_in    (f_rad),
      .tag_in    ({f_mr, f_mi, f_side, f_flg}),
      .valid_out (q_valid),
      .root_out  (q_root),
      .tag_out   (q_tag)
   );

   // Numerators with half the divisor added for rounding.
   assign {q_mr, q_mi, q_side, q_flg} = q_tag;
   assign num_a = {1'b0, q_mr, {Q_FRAC{1'b0}}} + NUM_W'(q_root >> 1);
   assign num_b = {1'b0, q_mi, {Q_FRAC{1'b0}}} + NUM_W'(q_root >> 1);

   pvbu_div #(.TAG_W(DTAG_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    ('{adv: adv, valid: q_valid}),
      .num_a_in  (num_a),
      .num_b_in  (num_b),
      .den_in    (q_root),
      .tag_in    ({q_side, q_flg}),
      .valid_out (d_valid),
      .quo_a_out (d_cm),
      .quo_b_out (d_sm),
      .tag_out   (d_tag)
   );

   assign {d_side, d_flg} = d_tag;

   pvbu_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    ('{adv: adv, valid: d_valid}),
      .cm_in     (d_cm),
      .sm_in     (d_sm),
      .flg_in    (d_flg),
      .side_in   (d_side),
      .valid_out (rsp_valid),
      .bin_out   (rsp_result_bin),
      .re_out    (rsp_out_real),
      .im_out    (rsp_out_imag),
      .degen_out (rsp_degenerate),
      .clip_out  (rsp_clipped)
   );
endmodule
`default_nettype wire

@@ hw/rtl/pvbu_front.sv @@
// Front section: input capture, reference phasor, normalization and radicand.
`default_nettype none
module pvbu_front
   import pvbu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire pipe_ctl_type                               ctl_in,
   input  wire logic [LEN_W-1:0]                           fft_len,
   input  wire logic [BIN_W-1:0]                           bin_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             sr_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             si_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             er_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             ei_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             yr_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]             yi_in,
   output logic                                            valid_out,
   output logic [RAD_W-1:0]                                rad_out,
   output logic [NORM_W-1:0]                               mr_out,
   output logic [NORM_W-1:0]                               mi_out,
   output logic [BIN_W+3+3*SAMPLE_WIDTH-1:0]               side_out,
   output logic [FLG_W-1:0]                                flg_out
);
   localparam int W = SAMPLE_WIDTH;
   localparam int MW = 2 * W + 1;
   localparam int MSB_W = $clog2(MW);
   localparam int EXT_W = MW + NORM_W;
   localparam int SH_W = $clog2(EXT_W) + 1;
   localparam int SIDE_W = BIN_W + 3 + 3 * W;
   localparam int NST = 7;
   localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};

   logic [NST-1:0] vld_ff, vld_in;

   // Stage 1: captured transaction.
   logic [BIN_W-1:0] bin1_ff;
   logic signed [W-1:0] sr1_ff, si1_ff, er1_ff, ei1_ff, yr1_ff, yi1_ff;

   // Stage 2: partial products and the real-bin answer.
   logic signed [2*W-1:0] yrsr2_ff, yisi2_ff, yrsi2_ff, yisr2_ff;
   logic [SIDE_W-1:0] side2_ff, side2_in;

   // Stage 3: reference phasor in sign-magnitude form.
   logic [MW-1:0] mr3_ff, mi3_ff, mr3_in, mi3_in;
   logic [FLG_W-1:0] flg3_ff, flg3_in;
   logic [SIDE_W-1:0] side3_ff;

   // Stage 4: leading one position.
   logic [MW-1:0] mr4_ff, mi4_ff;
   logic [MSB_W-1:0] msb4_ff, msb4_in;
   logic [FLG_W-1:0] flg4_ff;
   logic [SIDE_W-1:0] side4_ff;

   // Stage 5: normalized parts.
   logic [NORM_W-1:0] mr5_ff, mi5_ff, mr5_in, mi5_in;
   logic [FLG_W-1:0] flg5_ff;
   logic [SIDE_W-1:0] side5_ff;

   // Stage 6: squares.
   logic [2*NORM_W-1:0] sqr6_ff, sqi6_ff;
   logic [NORM_W-1:0] mr6_ff, mi6_ff;
   logic [FLG_W-1:0] flg6_ff;
   logic [SIDE_W-1:0] side6_ff;

   // Stage 7: radicand.
   logic [RAD_W-1:0] rad7_ff;
   logic [NORM_W-1:0] mr7_ff, mi7_ff;
   logic [FLG_W-1:0] flg7_ff;
   logic [SIDE_W-1:0] side7_ff;

   // Valid bits move with the data.
   assign vld_in = {vld_ff[NST-2:0], ctl_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   // Real-bin decision and its signed answer.
   always_comb begin
      logic is_real, rdeg, rclip;
      logic signed [W-1:0] rout;
      is_real = (bin1_ff == '0) ||
                (!fft_len[0] && (bin1_ff == fft_len[LEN_W-1:1]));
      rdeg = (sr1_ff == '0) || (yr1_ff == '0);
      rclip = 1'b0;
      rout = '0;
      if (!rdeg) begin
         if (sr1_ff[W-1] != yr1_ff[W-1]) begin
            if (er1_ff == S_MIN) begin
               rout = S_MAX;
               rclip = 1'b1;
            end else begin
               rout = -er1_ff;
            end
         end else begin
            rout = er1_ff;
         end
      end
      side2_in = {bin1_ff, is_real, rdeg, rclip, rout, er1_ff, ei1_ff};
   end

   // Reference phasor p = Yold * conj(Xs) as sign and magnitude.
   always_comb begin
      logic signed [MW-1:0] pr, pi;
      pr = MW'(yrsr2_ff) + MW'(yisi2_ff);
      pi = MW'(yisr2_ff) - MW'(yrsi2_ff);
      mr3_in = pr[MW-1] ? MW'(-pr) : MW'(pr);
      mi3_in = pi[MW-1] ? MW'(-pi) : MW'(pi);
      flg3_in = {pr[MW-1], pi[MW-1], (pr == '0) && (pi == '0)};
   end

   // The larger part and the OR of both share their leading one.
   always_comb begin
      logic [MW-1:0] both;
      both = mr3_ff | mi3_ff;
      msb4_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (both[i]) begin
            msb4_in = MSB_W'(i);
         end
      end
   end

   // Scale both parts so that the larger one, if nonzero, lands in [2^29, 2^30).
   always_comb begin
      logic [SH_W-1:0] pos;
      logic [EXT_W-1:0] xr, xi;
      pos = SH_W'(msb4_ff);
      xr = EXT_W'(mr4_ff);
      xi = EXT_W'(mi4_ff);
      if (pos >= SH_W'(NORM_TOP)) begin
         xr = xr >> (pos - SH_W'(NORM_TOP));
         xi = xi >> (pos - SH_W'(NORM_TOP));
      end else begin
         xr = xr << (SH_W'(NORM_TOP) - pos);
         xi = xi << (SH_W'(NORM_TOP) - pos);
      end
      mr5_in = xr[NORM_W-1:0];
      mi5_in = xi[NORM_W-1:0];
   end

   // Payload registers advance with the pipeline.
   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         bin1_ff <= bin_in;
         sr1_ff <= sr_in;
         si1_ff <= si_in;
         er1_ff <= er_in;
         ei1_ff <= ei_in;
         yr1_ff <= yr_in;
         yi1_ff <= yi_in;

         yrsr2_ff <= yr1_ff * sr1_ff;
         yisi2_ff <= yi1_ff * si1_ff;
         yrsi2_ff <= yr1_ff * si1_ff;
         yisr2_ff <= yi1_ff * sr1_ff;
         side2_ff <= side2_in;

         mr3_ff <= mr3_in;
         mi3_ff <= mi3_in;
         flg3_ff <= flg3_in;
         side3_ff <= side2_ff;

         mr4_ff <= mr3_ff;
         mi4_ff <= mi3_ff;
         msb4_ff <= msb4_in;
         flg4_ff <= flg3_ff;
         side4_ff <= side3_ff;

         mr5_ff <= mr5_in;
         mi5_ff <= mi5_in;
         flg5_ff <= flg4_ff;
         side5_ff <= side4_ff;

         sqr6_ff <= mr5_ff * mr5_ff;
         sqi6_ff <= mi5_ff * mi5_ff;
         mr6_ff <= mr5_ff;
         mi6_ff <= mi5_ff;
         flg6_ff <= flg5_ff;
         side6_ff <= side5_ff;

         rad7_ff <= RAD_W'(sqr6_ff) + RAD_W'(sqi6_ff);
         mr7_ff <= mr6_ff;
         mi7_ff <= mi6_ff;
         flg7_ff <= flg6_ff;
         side7_ff <= side6_ff;
      end
   end

   assign valid_out = vld_ff[NST-1];
   assign rad_out = rad7_ff;
   assign mr_out = mr7_ff;
   assign mi_out = mi7_ff;
   assign side_out = side7_ff;
   assign flg_out = flg7_ff;
endmodule
`default_nettype wire

@@ hw/rtl/pvbu_sqrt.sv @@
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module pvbu_sqrt
   import pvbu_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pipe_ctl_type         ctl_in,
   input  wire logic [RAD_W-1:0]     rad_in,
   input  wire logic [TAG_W-1:0]     tag_in,
   output logic                      valid_out,
   output logic [ROOT_W-1:0]         root_out,
   output logic [TAG_W-1:0]          tag_out
);
   localparam int REM_W = ROOT_W + 3;

   logic [ROOT_W-1:0] vld_ff, vld_in;
   logic [RAD_W-1:0]  rad_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_in_s [ROOT_W];
   logic [REM_W-1:0]  rem_ff [ROOT_W];
   logic [REM_W-1:0]  rem_in [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [TAG_W-1:0]  tag_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_in_s [ROOT_W];

   // One restoring step per stage: bring down two radicand bits, try a one.
   always_comb begin
      for (int s = 0; s < ROOT_W; s++) begin
         logic [RAD_W-1:0] rad_p;
         logic [REM_W-1:0] rem_p, remx, trial;
         logic [ROOT_W-1:0] root_p;
         if (s == 0) begin
            rad_p = rad_in;
            rem_p = '0;
            root_p = '0;
            tag_in_s[s] = tag_in;
            vld_in[s] = ctl_in.valid;
         end else begin
            rad_p = rad_ff[s-1];
            rem_p = rem_ff[s-1];
            root_p = root_ff[s-1];
            tag_in_s[s] = tag_ff[s-1];
            vld_in[s] = vld_ff[s-1];
         end
         remx = {rem_p[REM_W-3:0], rad_p[RAD_W-1:RAD_W-2]};
         trial = {1'b0, root_p, 2'b01};
         if (remx >= trial) begin
            rem_in[s] = remx - trial;
            root_in[s] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[s] = remx;
            root_in[s] = {root_p[ROOT_W-2:0], 1'b0};
         end
         rad_in_s[s] = rad_p << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         for (int s = 0; s < ROOT_W; s++) begin
            rad_ff[s] <= rad_in_s[s];
            rem_ff[s] <= rem_in[s];
            root_ff[s] <= root_in[s];
            tag_ff[s] <= tag_in_s[s];
         end
      end
   end

   assign valid_out = vld_ff[ROOT_W-1];
   assign root_out = root_ff[ROOT_W-1];
   assign tag_out = tag_ff[ROOT_W-1];
endmodule
`default_nettype wire

@@ hw/rtl/pvbu_div.sv @@
// Two-lane restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none
module pvbu_div
   import pvbu_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pipe_ctl_type         ctl_in,
   input  wire logic [NUM_W-1:0]     num_a_in,
   input  wire logic [NUM_W-1:0]     num_b_in,
   input  wire logic [ROOT_W-1:0]    den_in,
   input  wire logic [TAG_W-1:0]     tag_in,
   output logic                      valid_out,
   output logic [QUO_W-1:0]          quo_a_out,
   output logic [QUO_W-1:0]          quo_b_out,
   output logic [TAG_W-1:0]          tag_out
);
   localparam int RW = ROOT_W + 1;

   logic [QUO_W-1:0]  vld_ff, vld_in;
   logic [ROOT_W-1:0] den_ff [QUO_W];
   logic [ROOT_W-1:0] den_in_s [QUO_W];
   logic [TAG_W-1:0]  tag_ff [QUO_W];
   logic [TAG_W-1:0]  tag_in_s [QUO_W];
   logic [RW-1:0]     rem_ff [2][QUO_W];
   logic [RW-1:0]     rem_in [2][QUO_W];
   logic [QUO_W-1:0]  bits_ff [2][QUO_W];
   logic [QUO_W-1:0]  bits_in [2][QUO_W];
   logic [QUO_W-1:0]  quo_ff [2][QUO_W];
   logic [QUO_W-1:0]  quo_in [2][QUO_W];

   // The quotient fits QUO_W bits, so the top numerator bits start as remainder.
   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         logic [ROOT_W-1:0] den_p;
         if (s == 0) begin
            den_p = den_in;
            tag_in_s[s] = tag_in;
            vld_in[s] = ctl_in.valid;
         end else begin
            den_p = den_ff[s-1];
            tag_in_s[s] = tag_ff[s-1];
            vld_in[s] = vld_ff[s-1];
         end
         den_in_s[s] = den_p;
         for (int l = 0; l < 2; l++) begin
            logic [RW-1:0] rem_p, remx;
            logic [QUO_W-1:0] bits_p, quo_p;
            if (s == 0) begin
               if (l == 0) begin
                  rem_p = RW'(num_a_in[NUM_W-1:QUO_W]);
                  bits_p = num_a_in[QUO_W-1:0];
               end else begin
                  rem_p = RW'(num_b_in[NUM_W-1:QUO_W]);
                  bits_p = num_b_in[QUO_W-1:0];
               end
               quo_p = '0;
            end else begin
               rem_p = rem_ff[l][s-1];
               bits_p = bits_ff[l][s-1];
               quo_p = quo_ff[l][s-1];
            end
            remx = {rem_p[RW-2:0], bits_p[QUO_W-1]};
            if (remx >= RW'(den_p)) begin
               rem_in[l][s] = remx - RW'(den_p);
               quo_in[l][s] = {quo_p[QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l][s] = remx;
               quo_in[l][s] = {quo_p[QUO_W-2:0], 1'b0};
            end
            bits_in[l][s] = bits_p << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         for (int s = 0; s < QUO_W; s++) begin
            den_ff[s] <= den_in_s[s];
            tag_ff[s] <= tag_in_s[s];
            for (int l = 0; l < 2; l++) begin
               rem_ff[l][s] <= rem_in[l][s];
               bits_ff[l][s] <= bits_in[l][s];
               quo_ff[l][s] <= quo_in[l][s];
            end
         end
      end
   end

   assign valid_out = vld_ff[QUO_W-1];
   assign quo_a_out = quo_ff[0][QUO_W-1];
   assign quo_b_out = quo_ff[1][QUO_W-1];
   assign tag_out = tag_ff[QUO_W-1];
endmodule
`default_nettype wire

@@ hw/rtl/pvbu_back.sv @@
// Back section: phasor rotation of the end bin, rounding, saturation and result mux.
`default_nettype none
module pvbu_back
   import pvbu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire pipe_ctl_type                           ctl_in,
   input  wire logic [QUO_W-1:0]                       cm_in,
   input  wire logic [QUO_W-1:0]                       sm_in,
   input  wire logic [FLG_W-1:0]                       flg_in,
   input  wire logic [BIN_W+3+3*SAMPLE_WIDTH-1:0]      side_in,
   output logic                                        valid_out,
   output logic [BIN_W-1:0]                            bin_out,
   output logic signed [SAMPLE_WIDTH-1:0]              re_out,
   output logic signed [SAMPLE_WIDTH-1:0]              im_out,
   output logic                                        degen_out,
   output logic                                        clip_out
);
   localparam int W = SAMPLE_WIDTH;
   localparam int SIDE_W = BIN_W + 3 + 3 * W;
   localparam int CS_W = QUO_W + 1;
   localparam int PR_W = W + CS_W;
   localparam int X_W = PR_W + 1;
   localparam int RQ_W = X_W + 1 - Q_FRAC;
   localparam logic [RQ_W-1:0] POS_LIM = {{(RQ_W-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [RQ_W-1:0] NEG_LIM = POS_LIM + 1'b1;
   localparam logic [X_W:0] HALF = (X_W+1)'(1) << (Q_FRAC - 1);
   localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};

   logic [2:0] vld_ff, vld_in;

   // End bin parts carried in the side fields of the transaction.
   logic signed [W-1:0] s_er, s_ei;
   assign s_er = side_in[2*W-1:W];
   assign s_ei = side_in[W-1:0];

   // Stage 1: signed phasor times end bin.
   logic signed [PR_W-1:0] erc1_ff, eis1_ff, ers1_ff, eic1_ff;
   logic [FLG_W-1:0] flg1_ff, flg2_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff;

   // Stage 2: rotated parts before rounding.
   logic signed [X_W-1:0] xr2_ff, xi2_ff;

   // Stage 3: output register.
   logic [BIN_W-1:0] bin3_ff;
   logic signed [W-1:0] re3_ff, im3_ff, re3_in, im3_in;
   logic degen3_ff, clip3_ff, degen3_in, clip3_in;

   assign vld_in = {vld_ff[1:0], ctl_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   // Signed Q30 cosine and sine from the quotient magnitudes.
   logic signed [CS_W-1:0] c_sig, s_sig;
   assign c_sig = flg_in[2] ? -$signed({1'b0, cm_in}) : $signed({1'b0, cm_in});
   assign s_sig = flg_in[1] ? -$signed({1'b0, sm_in}) : $signed({1'b0, sm_in});

   // Round to nearest, ties away from zero, then saturate.
   function automatic logic [W:0] round_sat(input logic signed [X_W-1:0] x);
      logic [X_W-1:0] ax;
      logic [X_W:0] sum;
      logic [RQ_W-1:0] rq;
      logic [W-1:0] v;
      logic c;
      ax = x[X_W-1] ? X_W'(-x) : X_W'(x);
      sum = (X_W+1)'(ax) + HALF;
      rq = sum[X_W:Q_FRAC];
      c = 1'b0;
      if (x[X_W-1]) begin
         if (rq > NEG_LIM) begin
            v = S_MIN;
            c = 1'b1;
         end else begin
            v = -rq[W-1:0];
         end
      end else begin
         if (rq > POS_LIM) begin
            v = S_MAX;
            c = 1'b1;
         end else begin
            v = rq[W-1:0];
         end
      end
      return {c, v};
   endfunction

   // Final selection between real-bin, zero-reference and rotated results.
   always_comb begin
      logic rl, rd, rc;
      logic signed [W-1:0] ro;
      logic [W:0] rr, ri;
      rl = side2_ff[3*W+2];
      rd = side2_ff[3*W+1];
      rc = side2_ff[3*W];
      ro = side2_ff[3*W-1:2*W];
      rr = round_sat(xr2_ff);
      ri = round_sat(xi2_ff);
      if (rl) begin
         re3_in = ro;
         im3_in = '0;
         degen3_in = rd;
         clip3_in = rc;
      end else if (flg2_ff[0]) begin
         re3_in = '0;
         im3_in = '0;
         degen3_in = 1'b1;
         clip3_in = 1'b0;
      end else begin
         re3_in = rr[W-1:0];
         im3_in = ri[W-1:0];
         degen3_in = 1'b0;
         clip3_in = rr[W] | ri[W];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         erc1_ff <= s_er * c_sig;
         eis1_ff <= s_ei * s_sig;
         ers1_ff <= s_er * s_sig;
         eic1_ff <= s_ei * c_sig;
         flg1_ff <= flg_in;
         side1_ff <= side_in;

         xr2_ff <= X_W'(erc1_ff) - X_W'(eis1_ff);
         xi2_ff <= X_W'(ers1_ff) + X_W'(eic1_ff);
         flg2_ff <= flg1_ff;
         side2_ff <= side1_ff;

         bin3_ff <= side2_ff[SIDE_W-1:SIDE_W-BIN_W];
         re3_ff <= re3_in;
         im3_ff <= im3_in;
         degen3_ff <= degen3_in;
         clip3_ff <= clip3_in;
      end
   end

   assign valid_out = vld_ff[2];
   assign bin_out = bin3_ff;
   assign re_out = re3_ff;
   assign im_out = im3_ff;
   assign degen_out = degen3_ff;
   assign clip_out = clip3_ff;
endmodule
`default_nettype wire

@@ hw/rtl/pvbu_checker.sv @@
// Port-level checker of the bin update unit and its bind.
`default_nettype none
module pvbu_checker
   import pvbu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [SAMPLE_WIDTH-1:0]    rsp_out_real,
   input wire logic signed [SAMPLE_WIDTH-1:0]    rsp_out_imag,
   input wire logic                              rsp_degenerate,
   input wire logic                              rsp_clipped
);
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_real) &&
      $stable(rsp_out_imag))
      else $error("held result changed");

   // The input side stalls only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // A zero reference yields a zero result without clipping.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
      rsp_out_real == '0 && rsp_out_imag == '0 && !rsp_clipped)
      else $error("zero reference result not zero");

   // Clipping shows as a part at a rail.
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
      rsp_out_real == S_MAX || rsp_out_real == S_MIN ||
      rsp_out_imag == S_MAX || rsp_out_imag == S_MIN)
      else $error("clipped result not at a rail");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind phase_vocoder_bin_update_unit pvbu_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pvbu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_real   (rsp_out_real),
   .rsp_out_imag   (rsp_out_imag),
   .rsp_degenerate (rsp_degenerate),
   .rsp_clipped    (rsp_clipped)
);
`default_nettype wire
